// ===== rtl/sis_pkg.sv =====
// ----------------------------------------------------------------------------
// sis_pkg: shared constants and types for the sorted integer set
// Store geometry, field widths and action codes.
// ----------------------------------------------------------------------------
`default_nettype none

package sis_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned MCOUNT_W = 7;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 16;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

endpackage

`default_nettype wire

// ===== rtl/sis_ram.sv =====
// ----------------------------------------------------------------------------
// sis_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sis_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_integer_set.sv =====
// ----------------------------------------------------------------------------
// sorted_integer_set: set of distinct signed 32-bit integers in sorted order
// Insert, remove, query and clear on a fixed store with binary search.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. The block takes a beat only when its
// sequencer is idle; the result then sits in an output register while the
// next beat may be taken, and a result still held by the sink stalls the
// hand-over of the next one. A beat is accepted, then runs the binary-search
// steps over the n members (at most ceil(log2(n+1)) steps, each a read and a
// compare), a final read and the membership check. An insert of a new value
// and a remove of a member then move every larger entry one place through
// the single RAM read and write port, one entry a cycle, and the result is
// handed over last. An insert of a new value into a full store is refused
// and flagged; clear empties the set at once.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_integer_set (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output      logic                              s_axis_tready_o,
  input  wire logic [sis_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,  // [31:0] value
  input  wire logic [sis_pkg::ACTION_W-1:0]      s_axis_tuser_i,  // [1:0] action
  output      logic                              m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  output      logic [sis_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o   // [0] was_present,
                                                                  // [1] full_refused,
                                                                  // [8:2] member_count
);

  import sis_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_CHECK,
    ST_SHIFT,
    ST_DONE
  } state_e;

  state_e                     state_q, state_d;
  action_e                    act_q, act_d;
  logic signed [VALUE_W-1:0]  val_q, val_d;
  logic [CNT_W-1:0]           count_q, count_d;
  logic [CNT_W-1:0]           lo_q, lo_d;
  logic [CNT_W-1:0]           hi_q, hi_d;
  logic [CNT_W-1:0]           idx_q, idx_d;
  logic [CNT_W-1:0]           pend_addr_q, pend_addr_d;
  logic                       pend_q, pend_d;
  logic                       present_q, present_d;
  logic                       refused_q, refused_d;
  logic                       m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0]     m_data_q, m_data_d;

  logic [CNT_W-1:0]           mid;
  logic [CNT_W-1:0]           src;
  logic                       more;
  logic                       present;
  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_waddr;
  logic [VALUE_W-1:0]         ram_wdata;
  logic [ADDR_W-1:0]          ram_raddr;
  logic [VALUE_W-1:0]         ram_rdata;
  logic signed [VALUE_W-1:0]  rd_val;

  sis_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_val  = $signed(ram_rdata);
  assign mid     = lo_q + ((hi_q - lo_q) >> 1);
  assign present = (lo_q < count_q) && (rd_val == val_q);
  assign more    = (act_q == ACT_INSERT) ? (idx_q > lo_q) : ((idx_q + CNT_W'(1)) < count_q);
  assign src     = (act_q == ACT_INSERT) ? (idx_q - CNT_W'(1)) : (idx_q + CNT_W'(1));

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    val_d       = val_q;
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    present_d   = present_q;
    refused_d   = refused_q;
    m_valid_d   = m_valid_q;
    m_data_d    = m_data_q;
    ram_we      = 1'b0;
    ram_waddr   = pend_addr_q[ADDR_W-1:0];
    ram_wdata   = ram_rdata;
    ram_raddr   = lo_q[ADDR_W-1:0];

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          act_d     = action_e'(s_axis_tuser_i);
          val_d     = $signed(s_axis_tdata_i[VALUE_W-1:0]);
          lo_d      = '0;
          hi_d      = count_q;
          refused_d = 1'b0;
          pend_d    = 1'b0;
          state_d   = ST_SRCH_RD;
        end
      end
      ST_SRCH_RD: begin
        if (lo_q < hi_q) begin
          ram_raddr = mid[ADDR_W-1:0];
          state_d   = ST_SRCH_CMP;
        end else begin
          ram_raddr = lo_q[ADDR_W-1:0];
          state_d   = ST_CHECK;
        end
      end
      ST_SRCH_CMP: begin
        if (rd_val < val_q) begin
          lo_d = mid + CNT_W'(1);
        end else begin
          hi_d = mid;
        end
        state_d = ST_SRCH_RD;
      end
      ST_CHECK: begin
        present_d = present;
        state_d   = ST_DONE;
        unique case (act_q)
          ACT_INSERT: begin
            if (!present) begin
              if (count_q >= CNT_W'(CAPACITY)) begin
                refused_d = 1'b1;
              end else begin
                idx_d   = count_q;
                state_d = ST_SHIFT;
              end
            end
          end
          ACT_REMOVE: begin
            if (present) begin
              idx_d   = lo_q;
              state_d = ST_SHIFT;
            end
          end
          ACT_QUERY: begin
          end
          ACT_CLEAR: begin
            count_d = '0;
          end
          default: begin
          end
        endcase
      end
      ST_SHIFT: begin
        if (pend_q) begin
          ram_we = 1'b1;
        end
        if (more) begin
          ram_raddr   = src[ADDR_W-1:0];
          pend_d      = 1'b1;
          pend_addr_d = idx_q;
          idx_d       = src;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            if (act_q == ACT_INSERT) begin
              ram_we    = 1'b1;
              ram_waddr = lo_q[ADDR_W-1:0];
              ram_wdata = val_q;
              count_d   = count_q + CNT_W'(1);
            end else begin
              count_d   = count_q - CNT_W'(1);
            end
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {{(OUT_TDATA_W - MCOUNT_W - 2){1'b0}}, MCOUNT_W'(count_q),
                       refused_q, present_q};
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      act_q       <= ACT_QUERY;
      val_q       <= '0;
      count_q     <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      pend_addr_q <= '0;
      present_q   <= 1'b0;
      refused_q   <= 1'b0;
      m_valid_q   <= 1'b0;
      m_data_q    <= '0;
    end else begin
      state_q     <= state_d;
      act_q       <= act_d;
      val_q       <= val_d;
      count_q     <= count_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      pend_addr_q <= pend_addr_d;
      present_q   <= present_d;
      refused_q   <= refused_d;
      m_valid_q   <= m_valid_d;
      m_data_q    <= m_data_d;
    end
  end

endmodule

`default_nettype wire
